>>> rtl/core/assert_macros.svh
// Assertion macros shared by the shading pipeline.
// Clock aclk and active-low reset aresetn are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define TFSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// cond at one edge implies expr at the next
`define TFSC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/core/tfsc_pkg.sv
// Shared types and constants of the flat shading / backface cull pipeline.
// No dependencies.
package tfsc_pkg;

    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 16;
    localparam int AMB_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int E_W       = COORD_W + 1;
    localparam int SUM3_W    = COORD_W + 2;
    localparam int DIR_W     = COORD_W + 3;
    localparam int PROD_W    = 2 * E_W;
    localparam int VEC_W     = PROD_W + 1;
    localparam int MAG_W     = VEC_W - 1;
    localparam int SHIFT_W   = 5;
    localparam int SM_W      = 15;
    localparam int SQ_W      = 2 * SM_W;
    localparam int SUMSQ_W   = 32;
    localparam int ROOT_W    = SUMSQ_W / 2;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int UNIT_SHIFT = 14;
    localparam int QUO_W     = UNIT_SHIFT + 1;
    localparam int NUM_W     = SM_W + UNIT_SHIFT;
    localparam int DIV_W     = ROOT_W + UNIT_SHIFT;
    localparam int UNIT_W    = 16;
    localparam int DOTP_W    = 2 * UNIT_W;
    localparam int DOT_W     = DOTP_W + 2;
    localparam int CAM10_W   = DOT_W + 4;
    localparam int LAM_W     = DOT_W + 1;
    localparam int AMBW_W    = AMB_W + 1;
    localparam int LAMP_W    = LAM_W + AMBW_W;
    localparam int MIX_W     = LAMP_W + 1;
    localparam int Q_W       = 9;
    localparam int DOT_ONE_SHIFT = 28;
    localparam int MIX_ONE_SHIFT = 36;
    localparam int UNIT_LAT  = 6 + SQRT_STAGES + QUO_W + 1;
    localparam int SHADE_LAT = 5;

    localparam logic [Q_W-1:0] Q_FULL = 9'd256;

    typedef logic [VEC_W-1:0] vcomp_t;
    typedef vcomp_t [2:0] vec_t;
    typedef logic [UNIT_W-1:0] ucomp_t;
    typedef ucomp_t [2:0] unit_vec_t;

    typedef struct packed {
        unit_vec_t u;
        logic      nz;
    } unit_res_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               hidden;
        logic               last;
    } side_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_X = 3'd0,
        CFG_CAMERA_Y = 3'd1,
        CFG_CAMERA_Z = 3'd2,
        CFG_LIGHT_X  = 3'd3,
        CFG_LIGHT_Y  = 3'd4,
        CFG_LIGHT_Z  = 3'd5,
        CFG_AMBIENT  = 3'd6
    } cfg_index_t;

endpackage

>>> rtl/core/tfsc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tfsc_pkg.
module tfsc_div
    import tfsc_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output logic [QUO_W-1:0]  quo
);

    logic [NUM_W-1:0]  rem_reg [QUO_W-1];
    logic [ROOT_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0]  quo_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [NUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [DIV_W-1:0]  trial;
        logic [DIV_W-1:0]  rem_ext;
        logic              take;

        if (s == 0) begin : g_head
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_body
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial   = DIV_W'(den_in) << (QUO_W - 1 - s);
        assign rem_ext = DIV_W'(rem_in);
        assign take    = rem_ext >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[s] <= {quo_in[QUO_W-2:0], take};
            end
        end

        if (s < QUO_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= take ? NUM_W'(rem_ext - trial) : rem_in;
                    den_reg[s] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

>>> rtl/core/tfsc_unit.sv
// Vector normalizer: magnitude scaling, pipelined integer square root and
// three pipelined dividers giving a Q1.14 unit vector. Depends on tfsc_pkg, tfsc_div.
module tfsc_unit
    import tfsc_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  vec_t      vec,
    output unit_res_t res
);

    typedef logic [2:0][MAG_W-1:0] mag_vec_t;
    typedef logic [2:0][SM_W-1:0]  sm_vec_t;

    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [MAG_W-1:0] m);
        logic [SHIFT_W:0] bl;
        bl = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (m[i]) bl = (SHIFT_W+1)'(i + 1);
        end
        return (bl > (SHIFT_W+1)'(SM_W)) ? SHIFT_W'(bl - (SHIFT_W+1)'(SM_W)) : '0;
    endfunction

    mag_vec_t            mag1_reg, mag2_reg, mag3_reg;
    logic [MAG_W-1:0]    max2_reg;
    logic [SHIFT_W-1:0]  k3_reg;
    logic [2:0]          neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    sm_vec_t             sm4_reg, sm5_reg, sm6_reg;
    logic [2:0][SQ_W-1:0] sq5_reg;
    logic [SUMSQ_W-1:0]  sum6_reg;

    logic [SUMSQ_W-1:0]  x_reg    [SQRT_STAGES-1];
    logic [SUMSQ_W-1:0]  rt_reg   [SQRT_STAGES];
    sm_vec_t             smq_reg  [SQRT_STAGES];
    logic [2:0]          negq_reg [SQRT_STAGES];

    logic [2:0]          negd_reg [QUO_W];
    logic                zd_reg   [QUO_W];
    logic [2:0][QUO_W-1:0] quo;
    logic [ROOT_W-1:0]   len;
    unit_res_t           res_reg;

    // magnitudes, max, normalizing shift, squares, sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= vec[i][VEC_W-1];
                mag1_reg[i] <= vec[i][VEC_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
            end
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            max2_reg <= (mag1_reg[0] > mag1_reg[1])
                ? ((mag1_reg[0] > mag1_reg[2]) ? mag1_reg[0] : mag1_reg[2])
                : ((mag1_reg[1] > mag1_reg[2]) ? mag1_reg[1] : mag1_reg[2]);
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            k3_reg   <= norm_shift(max2_reg);
            for (int i = 0; i < 3; i++) begin
                sm4_reg[i] <= SM_W'(mag3_reg[i] >> k3_reg);
                sq5_reg[i] <= SQ_W'(sm4_reg[i]) * SQ_W'(sm4_reg[i]);
            end
            neg4_reg <= neg3_reg;
            sm5_reg  <= sm4_reg;
            neg5_reg <= neg4_reg;
            sum6_reg <= SUMSQ_W'(sq5_reg[0]) + SUMSQ_W'(sq5_reg[1]) + SUMSQ_W'(sq5_reg[2]);
            sm6_reg  <= sm5_reg;
            neg6_reg <= neg5_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
        logic [SUMSQ_W-1:0] x_in;
        logic [SUMSQ_W-1:0] r_in;
        sm_vec_t            sm_in;
        logic [2:0]         neg_in;
        logic [SUMSQ_W-1:0] bit_val;
        logic [SUMSQ_W:0]   trial;
        logic               take;

        if (s == 0) begin : g_head
            assign x_in   = sum6_reg;
            assign r_in   = '0;
            assign sm_in  = sm6_reg;
            assign neg_in = neg6_reg;
        end else begin : g_body
            assign x_in   = x_reg[s-1];
            assign r_in   = rt_reg[s-1];
            assign sm_in  = smq_reg[s-1];
            assign neg_in = negq_reg[s-1];
        end

        assign bit_val = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2 * s);
        assign trial   = (SUMSQ_W+1)'(r_in) + (SUMSQ_W+1)'(bit_val);
        assign take    = (SUMSQ_W+1)'(x_in) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rt_reg[s]   <= take ? (r_in >> 1) + bit_val : (r_in >> 1);
                smq_reg[s]  <= sm_in;
                negq_reg[s] <= neg_in;
            end
        end

        if (s < SQRT_STAGES - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[s] <= take ? SUMSQ_W'((SUMSQ_W+1)'(x_in) - trial) : x_in;
                end
            end
        end
    end

    assign len = rt_reg[SQRT_STAGES-1][ROOT_W-1:0];

    for (genvar i = 0; i < 3; i++) begin : g_div
        tfsc_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  ({smq_reg[SQRT_STAGES-1][i], UNIT_SHIFT'(0)}),
            .den  (len),
            .quo  (quo[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            negd_reg[0] <= negq_reg[SQRT_STAGES-1];
            zd_reg[0]   <= (len == '0);
            for (int s = 1; s < QUO_W; s++) begin
                negd_reg[s] <= negd_reg[s-1];
                zd_reg[s]   <= zd_reg[s-1];
            end
            for (int i = 0; i < 3; i++) begin
                if (zd_reg[QUO_W-1]) begin
                    res_reg.u[i] <= '0;
                end else if (negd_reg[QUO_W-1][i]) begin
                    res_reg.u[i] <= -UNIT_W'(quo[i]);
                end else begin
                    res_reg.u[i] <= UNIT_W'(quo[i]);
                end
            end
            res_reg.nz <= !zd_reg[QUO_W-1];
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/core/tfsc_shade.sv
// Dot products, cull test, Lambert/ambient intensity and color scaling.
// Depends on tfsc_pkg.
module tfsc_shade
    import tfsc_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  unit_res_t        un,
    input  unit_res_t        ul,
    input  unit_res_t        uc,
    input  logic [AMB_W-1:0] ambient,
    input  side_t            side_in,
    output side_t            side_out
);

    localparam logic signed [CAM10_W-1:0] DOT_ONE = CAM10_W'(1) <<< DOT_ONE_SHIFT;
    localparam logic signed [MIX_W-1:0]   MIX_ONE = MIX_W'(1) <<< MIX_ONE_SHIFT;

    logic signed [DOTP_W-1:0] pc_reg [3];
    logic signed [DOTP_W-1:0] pl_reg [3];
    logic signed [DOT_W-1:0]  camdot_reg, ldot_reg;
    logic signed [LAMP_W-1:0] lamp_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     ok1_reg, ok2_reg, ok3_reg;
    logic                     cull3_reg, cull4_reg;
    side_t                    side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;

    logic signed [CAM10_W-1:0] cam_ext, cam10;
    logic signed [LAM_W-1:0]   lam;
    logic signed [AMBW_W-1:0]  amb_s, amb_w;
    logic signed [MIX_W-1:0]   mix;
    logic [Q_W-1:0]            q_next;
    logic [7:0]                exp_r, exp_g, exp_b;
    logic [16:0]               pr, pg, pb;
    logic [COLOR_W-1:0]        lit;
    logic                      hid;

    always_comb begin
        cam_ext = CAM10_W'(camdot_reg);
        cam10   = (cam_ext <<< 3) + (cam_ext <<< 1);
        lam     = -LAM_W'(ldot_reg);
        amb_s   = $signed({1'b0, ambient});
        amb_w   = 10'sd256 - amb_s;
        mix     = (MIX_W'(amb_s) <<< DOT_ONE_SHIFT) + MIX_W'(lamp_reg);
        priority if (!ok3_reg || mix < 0) begin
            q_next = '0;
        end else if (mix > MIX_ONE) begin
            q_next = Q_FULL;
        end else begin
            q_next = mix[MIX_ONE_SHIFT:DOT_ONE_SHIFT];
        end
        exp_r = {side4_reg.color[15:11], 3'b000};
        exp_g = {side4_reg.color[10:5], 2'b00};
        exp_b = {side4_reg.color[4:0], 3'b000};
        pr    = 17'(exp_r) * 17'(q_reg);
        pg    = 17'(exp_g) * 17'(q_reg);
        pb    = 17'(exp_b) * 17'(q_reg);
        lit   = {pr[15:11], pg[15:10], pb[15:11]};
        hid   = side4_reg.hidden | cull4_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pc_reg[i] <= $signed(un.u[i]) * $signed(uc.u[i]);
                pl_reg[i] <= $signed(un.u[i]) * $signed(ul.u[i]);
            end
            ok1_reg   <= un.nz & ul.nz;
            side1_reg <= side_in;

            camdot_reg <= DOT_W'(pc_reg[0]) + DOT_W'(pc_reg[1]) + DOT_W'(pc_reg[2]);
            ldot_reg   <= DOT_W'(pl_reg[0]) + DOT_W'(pl_reg[1]) + DOT_W'(pl_reg[2]);
            ok2_reg    <= ok1_reg;
            side2_reg  <= side1_reg;

            cull3_reg <= cam10 > DOT_ONE;
            lamp_reg  <= LAMP_W'(lam) * LAMP_W'(amb_w);
            ok3_reg   <= ok2_reg;
            side3_reg <= side2_reg;

            q_reg     <= q_next;
            cull4_reg <= cull3_reg;
            side4_reg <= side3_reg;

            side5_reg.color  <= hid ? side4_reg.color : lit;
            side5_reg.hidden <= hid;
            side5_reg.last   <= side4_reg.last;
        end
    end

    assign side_out = side5_reg;

endmodule

>>> rtl/core/triangle_flat_shade_cull.sv
// Flat shading with backface culling, one triangle per item.
// One item per cycle sustained while m_ready stays high.
// Depth is set by the 16-stage square root and 15-stage dividers of the normalizers.
// A 2-entry output buffer lets input continue while one result waits.
// Reset: synchronous; clears config registers to zero and all valid bits.
`include "assert_macros.svh"
module triangle_flat_shade_cull
    import tfsc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [COORD_W-1:0]  s_vertex_a_x,
    input  logic signed [COORD_W-1:0]  s_vertex_a_y,
    input  logic signed [COORD_W-1:0]  s_vertex_a_z,
    input  logic signed [COORD_W-1:0]  s_vertex_b_x,
    input  logic signed [COORD_W-1:0]  s_vertex_b_y,
    input  logic signed [COORD_W-1:0]  s_vertex_b_z,
    input  logic signed [COORD_W-1:0]  s_vertex_c_x,
    input  logic signed [COORD_W-1:0]  s_vertex_c_y,
    input  logic signed [COORD_W-1:0]  s_vertex_c_z,
    input  logic [COLOR_W-1:0]         s_base_color,
    input  logic                       s_hidden_in,
    input  logic                       s_last_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [COLOR_W-1:0]         m_shaded_color,
    output logic                       m_hidden_out,
    output logic                       m_last_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COORD_W-1:0]         cfg_data
);

    logic signed [COORD_W-1:0] cam_reg [3];
    logic signed [COORD_W-1:0] light_reg [3];
    logic [AMB_W-1:0]          ambient_reg;

    logic en, push, pop;

    logic signed [COORD_W-1:0] a_reg [3], b_reg [3], c_reg [3];
    logic signed [E_W-1:0]     e1_reg [3], e2_reg [3];
    logic signed [DIR_W-1:0]   lv2_reg [3], cv2_reg [3], lv3_reg [3], cv3_reg [3];
    logic signed [DIR_W-1:0]   lv4_reg [3], cv4_reg [3];
    logic signed [PROD_W-1:0]  px_reg [3], qx_reg [3];
    logic signed [VEC_W-1:0]   n_reg [3];
    side_t                     side1_reg, side2_reg, side3_reg, side4_reg;
    logic [3:0]                vf_reg;

    side_t                     side_d_reg [UNIT_LAT];
    logic                      vu_reg [UNIT_LAT];
    logic                      vh_reg [SHADE_LAT];

    logic signed [SUM3_W-1:0]  s3 [3], l3 [3], c3 [3];
    vec_t                      n_vec, lv_vec, cv_vec;
    unit_res_t                 un, ul, uc;
    side_t                     pipe_out;

    side_t                     out_reg, skid_reg;
    logic                      out_valid_reg, skid_valid_reg;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                cam_reg[i]   <= '0;
                light_reg[i] <= '0;
            end
            ambient_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CAMERA_X: cam_reg[0]   <= cfg_data;
                CFG_CAMERA_Y: cam_reg[1]   <= cfg_data;
                CFG_CAMERA_Z: cam_reg[2]   <= cfg_data;
                CFG_LIGHT_X:  light_reg[0] <= cfg_data;
                CFG_LIGHT_Y:  light_reg[1] <= cfg_data;
                CFG_LIGHT_Z:  light_reg[2] <= cfg_data;
                CFG_AMBIENT:  ambient_reg  <= cfg_data[AMB_W-1:0];
                default: ;
            endcase
        end
    end

    // centroid kept as a+b+c; positions scaled by 3 to match
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s3[i] = SUM3_W'(a_reg[i]) + SUM3_W'(b_reg[i]) + SUM3_W'(c_reg[i]);
            l3[i] = (SUM3_W'(light_reg[i]) <<< 1) + SUM3_W'(light_reg[i]);
            c3[i] = (SUM3_W'(cam_reg[i]) <<< 1) + SUM3_W'(cam_reg[i]);
            n_vec[i]  = n_reg[i];
            lv_vec[i] = VEC_W'(lv4_reg[i]);
            cv_vec[i] = VEC_W'(cv4_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0] <= s_vertex_a_x; a_reg[1] <= s_vertex_a_y; a_reg[2] <= s_vertex_a_z;
            b_reg[0] <= s_vertex_b_x; b_reg[1] <= s_vertex_b_y; b_reg[2] <= s_vertex_b_z;
            c_reg[0] <= s_vertex_c_x; c_reg[1] <= s_vertex_c_y; c_reg[2] <= s_vertex_c_z;
            side1_reg <= '{color: s_base_color, hidden: s_hidden_in, last: s_last_in};

            for (int i = 0; i < 3; i++) begin
                e1_reg[i]  <= E_W'(b_reg[i]) - E_W'(a_reg[i]);
                e2_reg[i]  <= E_W'(c_reg[i]) - E_W'(a_reg[i]);
                lv2_reg[i] <= DIR_W'(s3[i]) - DIR_W'(l3[i]);
                cv2_reg[i] <= DIR_W'(s3[i]) - DIR_W'(c3[i]);
            end
            side2_reg <= side1_reg;

            px_reg[0] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[2]);
            qx_reg[0] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[1]);
            px_reg[1] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[0]);
            qx_reg[1] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[2]);
            px_reg[2] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[1]);
            qx_reg[2] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[0]);
            lv3_reg   <= lv2_reg;
            cv3_reg   <= cv2_reg;
            side3_reg <= side2_reg;

            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= VEC_W'(px_reg[i]) - VEC_W'(qx_reg[i]);
            end
            lv4_reg   <= lv3_reg;
            cv4_reg   <= cv3_reg;
            side4_reg <= side3_reg;

            side_d_reg[0] <= side4_reg;
            for (int s = 1; s < UNIT_LAT; s++) begin
                side_d_reg[s] <= side_d_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= '0;
            for (int s = 0; s < UNIT_LAT; s++) vu_reg[s] <= 1'b0;
            for (int s = 0; s < SHADE_LAT; s++) vh_reg[s] <= 1'b0;
        end else if (en) begin
            vf_reg    <= {vf_reg[2:0], s_valid};
            vu_reg[0] <= vf_reg[3];
            for (int s = 1; s < UNIT_LAT; s++) vu_reg[s] <= vu_reg[s-1];
            vh_reg[0] <= vu_reg[UNIT_LAT-1];
            for (int s = 1; s < SHADE_LAT; s++) vh_reg[s] <= vh_reg[s-1];
        end
    end

    tfsc_unit u_unit_n (.aclk(aclk), .en(en), .vec(n_vec),  .res(un));
    tfsc_unit u_unit_l (.aclk(aclk), .en(en), .vec(lv_vec), .res(ul));
    tfsc_unit u_unit_c (.aclk(aclk), .en(en), .vec(cv_vec), .res(uc));

    tfsc_shade u_shade (
        .aclk     (aclk),
        .en       (en),
        .un       (un),
        .ul       (ul),
        .uc       (uc),
        .ambient  (ambient_reg),
        .side_in  (side_d_reg[UNIT_LAT-1]),
        .side_out (pipe_out)
    );

    // output register plus skid entry
    assign push = en & vh_reg[SHADE_LAT-1];
    assign pop  = out_valid_reg & m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg  <= skid_valid_reg | push;
            skid_valid_reg <= skid_valid_reg & push;
        end else if (push) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (pop) begin
            out_reg <= skid_valid_reg ? skid_reg : pipe_out;
            if (push) skid_reg <= pipe_out;
        end else if (push) begin
            if (out_valid_reg) begin
                skid_reg <= pipe_out;
            end else begin
                out_reg <= pipe_out;
            end
        end else begin
            out_reg <= out_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_shaded_color = out_reg.color;
    assign m_hidden_out   = out_reg.hidden;
    assign m_last_out     = out_reg.last;

    `TFSC_ASSERT(a_skid_needs_out, !skid_valid_reg || out_valid_reg, "skid item without head item")
    `TFSC_ASSERT_NEXT(a_push_lands, push, out_valid_reg, "pipeline item dropped at output")
    `TFSC_ASSERT_NEXT(a_skid_held, skid_valid_reg && !pop, skid_valid_reg, "skid item lost")

endmodule
